FILE: rtl/tfhb_pkg.sv
// Shared types and constants of the timed frame history buffer.
package tfhb_pkg;

  // field widths
  localparam int TIME_W   = 48;
  localparam int BYTES_W  = 24;
  localparam int TOTAL_W  = 30;
  localparam int TQUOTA_W = 32;
  localparam int KIND_W   = 2;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int ENTRY_W  = TIME_W + BYTES_W;

  // defaults
  localparam int DEPTH_DEF = 64;
  localparam int ENOUGH_COUNT = 50;
  localparam logic [TOTAL_W-1:0]  MEM_QUOTA_RST  = 30'd67108864;
  localparam logic [TQUOTA_W-1:0] TIME_QUOTA_RST = 32'd10000;

  // opcodes
  localparam logic OPC_RECORD = 1'b0;
  localparam logic OPC_QUERY  = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MATCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_QUOTA  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_QUOTA = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [TIME_W-1:0]  frame_time;
    logic [BYTES_W-1:0] frame_bytes;
    logic [TIME_W-1:0]  range_start;
    logic [TIME_W-1:0]  range_end;
  } in_word_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TIME_W-1:0]  match_time;
    logic [BYTES_W-1:0] match_bytes;
    logic               last;
    logic               enough;
    logic [TOTAL_W-1:0] bytes_held;
    logic [TIME_W-1:0]  span_held;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REC_QUOTA,
    ST_REC_FULL,
    ST_LOAD,
    ST_APPEND,
    ST_REC_DONE,
    ST_CNT_RD,
    ST_CNT_CHK,
    ST_CNT_END,
    ST_EMIT_RD,
    ST_EMIT_CHK
  } state_t;

endpackage

FILE: rtl/tfhb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tfhb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/tfhb_cmp.sv
// Shared timestamp subtract and range compare unit.
module tfhb_cmp import tfhb_pkg::*; (
  input  logic [TIME_W-1:0] a,
  input  logic [TIME_W-1:0] b,
  input  logic [TIME_W-1:0] c,
  output logic [TIME_W-1:0] diff,
  output logic              a_ge_b,
  output logic              c_ge_a
);

  logic [TIME_W:0] sub_ab;
  logic [TIME_W:0] sub_ca;

  // borrow of each subtraction gives the compare
  assign sub_ab = {1'b0, a} - {1'b0, b};
  assign sub_ca = {1'b0, c} - {1'b0, a};
  assign diff   = sub_ab[TIME_W-1:0];
  assign a_ge_b = ~sub_ab[TIME_W];
  assign c_ge_a = ~sub_ca[TIME_W];

endmodule

FILE: rtl/timed_frame_history_buffer.sv
// Record: quota check, full-store check, append, then a registered result word; a quota
//   or full-store eviction also passes through ST_LOAD, reloading the oldest entry from RAM.
// Query: a counting pass reads and tests each entry until the newest or one past the
//   range end, then a second pass reads each entry and emits the matches up to the last.
// One item at a time; busy is high until the last word is issued; results are never held off.
// Synchronous active-low reset empties the store and loads default quotas.
module timed_frame_history_buffer import tfhb_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_word_t             in_data,
  output logic                 out_valid,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  state_t state_r, state_nxt;

  logic [TOTAL_W-1:0]  mq_r;
  logic [TQUOTA_W-1:0] tq_r;

  in_word_t            in_r;
  logic [SLOT_W-1:0]   oldest_slot_r, oldest_slot_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [TIME_W-1:0]   oldest_time_r, oldest_time_nxt;
  logic [BYTES_W-1:0]  oldest_bytes_r, oldest_bytes_nxt;
  logic [TIME_W-1:0]   newest_time_r, newest_time_nxt;
  logic [TIME_W-1:0]   span_r, span_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    nmatch_r, nmatch_nxt;
  logic [CNT_W-1:0]    sent_r, sent_nxt;
  logic                enough_r, enough_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_r, out_nxt;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [SLOT_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [TIME_W-1:0]   rd_time;
  logic [BYTES_W-1:0]  rd_bytes;

  logic [TIME_W-1:0]   cmp_a, cmp_b, cmp_diff;
  logic                ge_lo, le_hi, in_range, past_end;

  logic                quota_hit, full, evict;
  logic [SLOT_W-1:0]   oldest_inc;
  logic [TOTAL_W:0]    add_sum;

  // ring slot at an offset from the oldest entry
  function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] base,
                                                input logic [CNT_W-1:0] ofs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(ofs);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[SLOT_W-1:0];
  endfunction

  assign rd_time  = ram_rdata[ENTRY_W-1:BYTES_W];
  assign rd_bytes = ram_rdata[BYTES_W-1:0];

  tfhb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_r.frame_time, in_r.frame_bytes}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared unit: span on record completion, range test while scanning
  assign cmp_a = (state_r == ST_REC_DONE) ? newest_time_r : rd_time;
  assign cmp_b = (state_r == ST_REC_DONE) ? oldest_time_r : in_r.range_start;

  tfhb_cmp u_cmp (
    .a      (cmp_a),
    .b      (cmp_b),
    .c      (in_r.range_end),
    .diff   (cmp_diff),
    .a_ge_b (ge_lo),
    .c_ge_a (le_hi)
  );

  assign in_range = ge_lo & le_hi;
  assign past_end = ge_lo & ~le_hi;

  // eviction conditions
  assign quota_hit  = (count_r != '0) &&
                      ((total_r >= mq_r) || (span_r >= TIME_W'(tq_r)));
  assign full       = (count_r == CNT_W'(DEPTH));
  assign evict      = ((state_r == ST_REC_QUOTA) && quota_hit) ||
                      ((state_r == ST_REC_FULL) && full);
  assign oldest_inc = (oldest_slot_r == SLOT_W'(DEPTH - 1)) ? '0 :
                      oldest_slot_r + 1'b1;
  assign add_sum    = {1'b0, total_r} + (TOTAL_W + 1)'(in_r.frame_bytes);

  // RAM addressing
  assign ram_we    = (state_r == ST_APPEND);
  assign ram_waddr = slot_of(oldest_slot_r, count_r);
  assign ram_raddr = evict ? oldest_inc : slot_of(oldest_slot_r, idx_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_data.opcode == OPC_QUERY) ? ST_CNT_RD : ST_REC_QUOTA;
        end
      end
      ST_REC_QUOTA: state_nxt = quota_hit ? ST_LOAD : ST_REC_FULL;
      ST_REC_FULL:  state_nxt = full ? ST_LOAD : ST_APPEND;
      ST_LOAD:      state_nxt = ST_REC_FULL;
      ST_APPEND:    state_nxt = ST_REC_DONE;
      ST_REC_DONE:  state_nxt = ST_IDLE;
      ST_CNT_RD:    state_nxt = (idx_r == count_r) ? ST_CNT_END : ST_CNT_CHK;
      ST_CNT_CHK:   state_nxt = past_end ? ST_CNT_END : ST_CNT_RD;
      ST_CNT_END:   state_nxt = (nmatch_r == '0) ? ST_IDLE : ST_EMIT_RD;
      ST_EMIT_RD:   state_nxt = ST_EMIT_CHK;
      ST_EMIT_CHK: begin
        if (in_range && (sent_r + CNT_W'(1) == nmatch_r)) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and result word
  always_comb begin
    oldest_slot_nxt  = oldest_slot_r;
    count_nxt        = count_r;
    total_nxt        = total_r;
    oldest_time_nxt  = oldest_time_r;
    oldest_bytes_nxt = oldest_bytes_r;
    newest_time_nxt  = newest_time_r;
    span_nxt         = span_r;
    idx_nxt          = idx_r;
    nmatch_nxt       = nmatch_r;
    sent_nxt         = sent_r;
    enough_nxt       = enough_r;
    out_valid_nxt    = 1'b0;
    out_nxt          = out_r;

    // drop the oldest entry, flooring the byte total
    if (evict) begin
      total_nxt       = (total_r >= TOTAL_W'(oldest_bytes_r)) ?
                        total_r - TOTAL_W'(oldest_bytes_r) : '0;
      oldest_slot_nxt = oldest_inc;
      count_nxt       = count_r - 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        idx_nxt    = '0;
        nmatch_nxt = '0;
        sent_nxt   = '0;
      end
      ST_LOAD: begin
        oldest_time_nxt  = rd_time;
        oldest_bytes_nxt = rd_bytes;
      end
      ST_APPEND: begin
        newest_time_nxt = in_r.frame_time;
        if (count_r == '0) begin
          oldest_time_nxt  = in_r.frame_time;
          oldest_bytes_nxt = in_r.frame_bytes;
        end
        count_nxt = count_r + 1'b1;
        total_nxt = add_sum[TOTAL_W] ? '1 : add_sum[TOTAL_W-1:0];
      end
      ST_REC_DONE: begin
        span_nxt            = cmp_diff;
        out_valid_nxt       = 1'b1;
        out_nxt.kind        = KIND_ACK;
        out_nxt.match_time  = '0;
        out_nxt.match_bytes = '0;
        out_nxt.last        = 1'b1;
        out_nxt.enough      = 1'b0;
        out_nxt.bytes_held  = total_r;
        out_nxt.span_held   = cmp_diff;
      end
      ST_CNT_CHK: begin
        idx_nxt = idx_r + 1'b1;
        if (in_range) begin
          nmatch_nxt = nmatch_r + 1'b1;
        end
      end
      ST_CNT_END: begin
        idx_nxt    = '0;
        enough_nxt = (32'(nmatch_r) >= ENOUGH_COUNT);
        if (nmatch_r == '0) begin
          out_valid_nxt       = 1'b1;
          out_nxt.kind        = KIND_NONE;
          out_nxt.match_time  = '0;
          out_nxt.match_bytes = '0;
          out_nxt.last        = 1'b1;
          out_nxt.enough      = 1'b0;
          out_nxt.bytes_held  = total_r;
          out_nxt.span_held   = span_r;
        end
      end
      ST_EMIT_CHK: begin
        idx_nxt = idx_r + 1'b1;
        if (in_range) begin
          sent_nxt            = sent_r + 1'b1;
          out_valid_nxt       = 1'b1;
          out_nxt.kind        = KIND_MATCH;
          out_nxt.match_time  = rd_time;
          out_nxt.match_bytes = rd_bytes;
          out_nxt.last        = (sent_r + CNT_W'(1) == nmatch_r);
          out_nxt.enough      = enough_r;
          out_nxt.bytes_held  = total_r;
          out_nxt.span_held   = span_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      oldest_slot_r <= '0;
      count_r       <= '0;
      total_r       <= '0;
      span_r        <= '0;
      out_valid_r   <= 1'b0;
      mq_r          <= MEM_QUOTA_RST;
      tq_r          <= TIME_QUOTA_RST;
    end else begin
      state_r       <= state_nxt;
      oldest_slot_r <= oldest_slot_nxt;
      count_r       <= count_nxt;
      total_r       <= total_nxt;
      span_r        <= span_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MEM_QUOTA:  mq_r <= cfg_wdata[TOTAL_W-1:0];
          CFG_TIME_QUOTA: tq_r <= cfg_wdata[TQUOTA_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && start) begin
      in_r <= in_data;
    end
    oldest_time_r  <= oldest_time_nxt;
    oldest_bytes_r <= oldest_bytes_nxt;
    newest_time_r  <= newest_time_nxt;
    idx_r          <= idx_nxt;
    nmatch_r       <= nmatch_nxt;
    sent_r         <= sent_nxt;
    enough_r       <= enough_nxt;
    out_r          <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: tb/sv/tb.sv
// Testbench for the timed frame history buffer: directed and random words vs a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tfhb_pkg::*;

  localparam int SLOTS = DEPTH_DEF;
  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_word_t             in_data;
  logic                 out_valid;
  out_word_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  timed_frame_history_buffer uut (.*);

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted history state
  logic [TIME_W-1:0]   hist_time  [SLOTS];
  logic [BYTES_W-1:0]  hist_bytes [SLOTS];
  int                  hist_head;
  int                  hist_count;
  logic [TOTAL_W-1:0]  hist_total;
  logic [TOTAL_W-1:0]  mem_quota;
  logic [TQUOTA_W-1:0] span_limit;

  out_word_t          due_words[$];
  int                 err_count;
  bit                 idle_en;
  logic [TIME_W-1:0]  newest_time;

  task automatic report_mismatch(string msg);
    if (err_count < 40) $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [TIME_W-1:0] held_span();
    if (hist_count == 0) return '0;
    return hist_time[(hist_head + hist_count - 1) % SLOTS] - hist_time[hist_head];
  endfunction

  // drop the oldest frame, floor the byte total at zero
  function automatic void drop_oldest();
    if (hist_count == 0) return;
    hist_total = (hist_total >= hist_bytes[hist_head]) ?
                 hist_total - hist_bytes[hist_head] : '0;
    hist_head  = (hist_head + 1) % SLOTS;
    hist_count--;
  endfunction

  function automatic out_word_t held_word(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] t,
                                          logic [BYTES_W-1:0] b, logic fin);
    out_word_t w;
    w.kind        = kind;
    w.match_time  = t;
    w.match_bytes = b;
    w.last        = fin;
    w.enough      = 1'b0;
    w.bytes_held  = hist_total;
    w.span_held   = held_span();
    return w;
  endfunction

  // update the history for one accepted word and queue the words it causes
  function automatic void predict_word(in_word_t w);
    out_word_t          hits[$];
    int                 slot;
    logic [TOTAL_W:0]   sum;
    logic [TIME_W-1:0]  t;
    if (w.opcode == OPC_RECORD) begin
      if (hist_count > 0 &&
          (hist_total >= mem_quota || held_span() >= {16'b0, span_limit}))
        drop_oldest();
      if (hist_count >= SLOTS) drop_oldest();
      slot = (hist_head + hist_count) % SLOTS;
      hist_time[slot]  = w.frame_time;
      hist_bytes[slot] = w.frame_bytes;
      hist_count++;
      sum = hist_total + w.frame_bytes;
      hist_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      due_words.push_back(held_word(KIND_ACK, '0, '0, 1'b1));
    end else begin
      for (int i = 0; i < hist_count; i++) begin
        t = hist_time[(hist_head + i) % SLOTS];
        if (t >= w.range_start) begin
          if (t > w.range_end) break;
          hits.push_back(held_word(KIND_MATCH, t, hist_bytes[(hist_head + i) % SLOTS], 1'b0));
        end
      end
      if (hits.size() == 0) begin
        due_words.push_back(held_word(KIND_NONE, '0, '0, 1'b1));
      end else begin
        foreach (hits[k]) begin
          hits[k].enough = (hits.size() >= ENOUGH_COUNT);
          hits[k].last   = (k == hits.size() - 1);
          due_words.push_back(hits[k]);
        end
      end
    end
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[TIME_W-1:0];
  endfunction

  function automatic logic [BYTES_W-1:0] rand_bytes();
    logic [31:0] r;
    r = $urandom();
    return r[BYTES_W-1:0];
  endfunction

  // unused fields carry random bits
  function automatic in_word_t record_word(logic [TIME_W-1:0] t, logic [BYTES_W-1:0] b);
    in_word_t w;
    w.opcode      = OPC_RECORD;
    w.frame_time  = t;
    w.frame_bytes = b;
    w.range_start = rand_time();
    w.range_end   = rand_time();
    return w;
  endfunction

  function automatic in_word_t query_word(logic [TIME_W-1:0] lo, logic [TIME_W-1:0] hi);
    in_word_t w;
    w.opcode      = OPC_QUERY;
    w.frame_time  = rand_time();
    w.frame_bytes = rand_bytes();
    w.range_start = lo;
    w.range_end   = hi;
    return w;
  endfunction

  // mostly in-order records and queries aimed at held frames, some noise
  function automatic in_word_t random_word();
    int                pick;
    int                a;
    int                b;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    logic [BYTES_W-1:0] sz;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      newest_time += $urandom_range(0, 300);
      sz = ($urandom_range(0, 9) == 0) ? rand_bytes() : BYTES_W'($urandom_range(0, 1 << 20));
      return record_word(newest_time, sz);
    end else if (pick < 85 && hist_count > 0) begin
      a  = $urandom_range(0, hist_count - 1);
      b  = $urandom_range(a, hist_count - 1);
      lo = hist_time[(hist_head + a) % SLOTS] - $urandom_range(0, 2);
      hi = hist_time[(hist_head + b) % SLOTS] + $urandom_range(0, 2);
      return query_word(lo, hi);
    end else if (pick < 92) begin
      return record_word(rand_time(), rand_bytes());
    end
    return query_word(rand_time(), rand_time());
  endfunction

  // hold start until the block takes the word, with an optional gap first
  task automatic send_word(in_word_t w);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    predict_word(w);
  endtask

  // wait for every queued word and for the block to go idle
  task automatic drain();
    int guard;
    start <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while ((due_words.size() != 0 || busy) && guard < 5000);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_MEM_QUOTA) mem_quota = val[TOTAL_W-1:0];
    else span_limit = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // check each result word against the oldest prediction
  always @(posedge clk) begin : check_words
    out_word_t want;
    if (rst_n && out_valid) begin
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word, kind %0d", out_data.kind));
      end else begin
        want = due_words[0];
        due_words.delete(0);
        if (out_data.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_data.kind, want.kind));
        if (out_data.match_time !== want.match_time)
          report_mismatch($sformatf("match_time %0h, want %0h",
                                    out_data.match_time, want.match_time));
        if (out_data.match_bytes !== want.match_bytes)
          report_mismatch($sformatf("match_bytes %0h, want %0h",
                                    out_data.match_bytes, want.match_bytes));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_data.last, want.last));
        if (out_data.enough !== want.enough)
          report_mismatch($sformatf("enough %0b, want %0b", out_data.enough, want.enough));
        if (out_data.bytes_held !== want.bytes_held)
          report_mismatch($sformatf("bytes_held %0h, want %0h",
                                    out_data.bytes_held, want.bytes_held));
        if (out_data.span_held !== want.span_held)
          report_mismatch($sformatf("span_held %0h, want %0h",
                                    out_data.span_held, want.span_held));
      end
    end
  end

  // empty store, range edges, wrapped span
  task automatic test_basic_paths();
    send_word(query_word('0, TIME_MAX));
    send_word(record_word('0, '0));
    send_word(record_word(48'd100, BYTES_MAX));
    send_word(query_word('0, TIME_MAX));
    // start after end
    send_word(query_word(48'd50, 48'd10));
    send_word(query_word(48'd100, 48'd100));
    // newest frame already past the end
    send_word(query_word('0, 48'd99));
    send_word(record_word(TIME_MAX, 24'd1));
    // out-of-order frame: forces a time eviction, and the span wraps
    send_word(record_word(48'd5, 24'd2));
    send_word(query_word('0, TIME_MAX));
    send_word(query_word(TIME_MAX, TIME_MAX));
    drain();
  endtask

  // quota extremes, full-store eviction and the match-count threshold
  task automatic test_quota_limits();
    logic [TIME_W-1:0] base;
    write_reg(CFG_MEM_QUOTA, '0);
    write_reg(CFG_TIME_QUOTA, '1);
    repeat (3) send_word(record_word(rand_time(), rand_bytes()));
    send_word(query_word('0, TIME_MAX));
    drain();
    write_reg(CFG_MEM_QUOTA, {2'b00, TOTAL_MAX});
    write_reg(CFG_TIME_QUOTA, '0);
    repeat (3) send_word(record_word(rand_time(), rand_bytes()));
    send_word(query_word('0, TIME_MAX));
    drain();
    // fill past depth with both quotas open
    write_reg(CFG_TIME_QUOTA, '1);
    for (int i = 0; i < SLOTS + 2; i++)
      send_word(record_word(48'd1000 + i * 10, rand_bytes()));
    base = 48'd1020;
    send_word(query_word('0, TIME_MAX));
    send_word(query_word(base, base + 48 * 10));
    send_word(query_word(base, base + 49 * 10));
    drain();
  endtask

  // random phases under different quota settings, last one without gaps
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_MEM_QUOTA, {2'b00, MEM_QUOTA_RST});
          write_reg(CFG_TIME_QUOTA, TIME_QUOTA_RST);
        end
        1: begin
          write_reg(CFG_MEM_QUOTA, $urandom_range(1 << 20, 1 << 25));
          write_reg(CFG_TIME_QUOTA, $urandom_range(0, 20000));
        end
        2: begin
          write_reg(CFG_MEM_QUOTA, {2'b00, TOTAL_MAX});
          write_reg(CFG_TIME_QUOTA, $urandom() | 32'h1000_0000);
        end
        default: begin
          write_reg(CFG_MEM_QUOTA, $urandom_range(1 << 24, 1 << 28));
          write_reg(CFG_TIME_QUOTA, $urandom_range(1000, 8000));
          idle_en = 1'b0;
        end
      endcase
      repeat (73) send_word(random_word());
      drain();
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    hist_head   = 0;
    hist_count  = 0;
    hist_total  = '0;
    mem_quota   = MEM_QUOTA_RST;
    span_limit  = TIME_QUOTA_RST;
    err_count   = 0;
    idle_en     = 1'b1;
    newest_time = 48'd5000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_paths();
    test_quota_limits();
    test_random_traffic();
    drain();
    if (due_words.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", due_words.size()));
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // stop a hung run
  initial begin
    #20_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tfhb_pkg.sv
rtl/tfhb_ram.sv
rtl/tfhb_cmp.sv
rtl/timed_frame_history_buffer.sv
tb/sv/tb.sv
